// ----- sv/dbt_pkg.sv -----
// Package for the dual bound tightening table unit.
// Knowledge codes, sense codes, sequencer states and shared constants.
// No dependencies.
`timescale 1ns / 1ps
package dbt_pkg;
  localparam int ENTRIES_DEFAULT = 1024;
  localparam logic [30:0] TOL_RESET = 31'd1;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_LOW   = 3'd1,
    K_HIGH  = 3'd2,
    K_BOTH  = 3'd3,
    K_FIXED = 3'd4
  } know_t;

  typedef enum logic [1:0] {
    S_EQ = 2'd0,
    S_LE = 2'd1,
    S_GE = 2'd2,
    S_NONE = 2'd3
  } sense_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_UPD,
    ST_COLL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] cost;
    logic [31:0] coef;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage

// ----- sv/dbt_div.sv -----
// Iterative signed Q16.16 divider: (cost * 2^16) / coef, truncated and saturated.
// One quotient bit per cycle, 48 quotient bits in all. Uses dbt_pkg.
`timescale 1ns / 1ps
module dbt_div (
  input  logic              clk,
  input  logic              rst,
  input  dbt_pkg::div_req_t req,
  output dbt_pkg::div_rsp_t rsp
);
  logic [47:0] num;
  logic [31:0] den;
  logic [48:0] rem;
  logic [47:0] quo;
  logic [5:0]  cnt;
  logic        neg;
  logic        zero_den;
  logic        cost_pos;
  logic        cost_zero;
  logic        busy;
  logic        done;
  logic [48:0] trial;
  logic [47:0] mag;
  logic [31:0] quo_out;

  assign trial = {rem[47:0], num[47]} - {17'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        rem <= '0;
        quo <= '0;
        neg <= req.cost[31] ^ req.coef[31];
        zero_den <= (req.coef == 32'd0);
        cost_pos <= !req.cost[31] && (req.cost != 32'd0);
        cost_zero <= (req.cost == 32'd0);
        num <= {(req.cost[31] ? 32'(-req.cost) : req.cost), 16'd0};
        den <= req.coef[31] ? 32'(-req.coef) : req.coef;
      end else if (busy) begin
        num <= {num[46:0], 1'b0};
        if (!trial[48]) begin
          rem <= trial;
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[47:0], num[47]};
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign mag = quo;
  always_comb begin
    if (zero_den) begin
      quo_out = cost_zero ? 32'd0 : (cost_pos ? 32'h7FFF_FFFF : 32'h8000_0000);
    end else if (!neg) begin
      quo_out = (mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      quo_out = (mag >= 48'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = quo_out;
endmodule

// ----- sv/dual_bound_tightening_table_unit.sv -----
// Dual bound tightening table unit: top level with table memories and sequencer.
// Request channel in, result channel out, APB register port.
// Depends on dbt_pkg and dbt_div.
//
// Usage:
//   A request (entry_index, reduced_cost, coefficient, sense) is taken when
//   in_valid and in_ready are high. One result (changes, known_state,
//   dual_value, lower_bound, upper_bound) follows on out_valid/out_ready.
//   A result is valid after one memory read, the 48-step bit-serial divider and
//   its done flag, then update, collapse and output load with write back. A fixed
//   or out-of-range entry skips the divider and goes from the read straight to
//   the output load.
//   One request is in flight at a time; a new request is taken only after the
//   previous one has been loaded into the output register.
//   After reset a clearing pass zeroes the knowledge
//   memory, one entry a cycle; in_ready stays low meanwhile.
//   A stalled receiver holds the result in the output register; the next
//   request is taken while that result waits, but not finished until it leaves.
//   Register 0 at address 0: collapse_tolerance (31 bits, reset 1).
`timescale 1ns / 1ps
module dual_bound_tightening_table_unit #(
  parameter int ENTRIES = dbt_pkg::ENTRIES_DEFAULT,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  entry_index,
  input  logic signed [31:0] reduced_cost,
  input  logic signed [31:0] coefficient,
  input  logic [1:0]  sense,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  changes,
  output logic [2:0]  known_state,
  output logic signed [31:0] dual_value,
  output logic signed [31:0] lower_bound,
  output logic signed [31:0] upper_bound,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [30:0] tol;
  assign pready = 1'b1;
  assign prdata = {1'b0, tol};
  always_ff @(posedge clk) begin
    if (rst) tol <= dbt_pkg::TOL_RESET;
    else if (psel && penable && pwrite && (paddr == 1'b0)) tol <= pwdata[30:0];
  end

  logic [2:0]  kmem [ENTRIES];
  logic [31:0] fmem [ENTRIES];
  logic [31:0] lmem [ENTRIES];
  logic [31:0] hmem [ENTRIES];
  logic [2:0]  k_rd;
  logic [31:0] f_rd, l_rd, h_rd;
  logic        we;
  logic [AW-1:0] wa, ra;
  logic [2:0]  k_wd;
  logic [31:0] f_wd, l_wd, h_wd;

  always_ff @(posedge clk) begin
    if (we) begin
      kmem[wa] <= k_wd;
      fmem[wa] <= f_wd;
      lmem[wa] <= l_wd;
      hmem[wa] <= h_wd;
    end
    k_rd <= kmem[ra];
    f_rd <= fmem[ra];
    l_rd <= lmem[ra];
    h_rd <= hmem[ra];
  end

  dbt_pkg::state_t state, state_next;
  logic [AW:0]   clr;
  logic [AW-1:0] idx;
  logic [31:0]   cost, coef;
  logic [1:0]    sns;
  logic          oor;
  logic [2:0]    k;
  logic [31:0]   fv, lb, hb;
  logic [1:0]    chg;
  logic [31:0]   q;
  dbt_pkg::div_req_t dreq;
  dbt_pkg::div_rsp_t drsp;

  dbt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      dbt_pkg::ST_CLEAR: if (clr == (AW+1)'(ENTRIES - 1)) state_next = dbt_pkg::ST_IDLE;
      dbt_pkg::ST_IDLE:  if (in_fire) state_next = dbt_pkg::ST_READ;
      dbt_pkg::ST_READ:  state_next = (oor || (k_rd == dbt_pkg::K_FIXED)) ?
                                      dbt_pkg::ST_OUT : dbt_pkg::ST_DIV;
      dbt_pkg::ST_DIV:   if (drsp.done) state_next = dbt_pkg::ST_UPD;
      dbt_pkg::ST_UPD:   state_next = dbt_pkg::ST_COLL;
      dbt_pkg::ST_COLL:  state_next = dbt_pkg::ST_OUT;
      dbt_pkg::ST_OUT:   if (!out_valid || out_ready) state_next = dbt_pkg::ST_IDLE;
      default:           state_next = dbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == dbt_pkg::ST_IDLE);
    dreq.start = (state == dbt_pkg::ST_READ) && !oor && (k_rd != dbt_pkg::K_FIXED);
    dreq.cost = cost;
    dreq.coef = coef;
    ra = in_fire ? AW'(entry_index) : idx;
    we = (state == dbt_pkg::ST_CLEAR) ||
         ((state == dbt_pkg::ST_OUT) && !oor && (!out_valid || out_ready));
    wa = (state == dbt_pkg::ST_CLEAR) ? clr[AW-1:0] : idx;
    k_wd = (state == dbt_pkg::ST_CLEAR) ? dbt_pkg::K_NONE : k;
    f_wd = fv;
    l_wd = lb;
    h_wd = hb;
  end

  logic        raise_low;
  logic signed [32:0] gap;
  logic [32:0] agap;
  logic [32:0] sum;
  assign raise_low = ((!coef[31]) && (coef != 32'd0)) == (sns == dbt_pkg::S_LE);
  assign gap = $signed({lb[31], lb}) - $signed({hb[31], hb});
  assign agap = gap[32] ? 33'(-gap) : 33'(gap);
  assign sum = {lb[31], lb} + {hb[31], hb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbt_pkg::ST_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dbt_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if ((state == dbt_pkg::ST_OUT) && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
    if (in_fire) begin
      idx <= AW'(entry_index);
      oor <= (32'(entry_index) >= 32'(ENTRIES));
      cost <= reduced_cost;
      coef <= coefficient;
      sns <= sense;
    end
    if (state == dbt_pkg::ST_READ) begin
      k <= k_rd;
      fv <= f_rd;
      lb <= l_rd;
      hb <= h_rd;
      chg <= 2'd0;
    end
    if (drsp.done) q <= drsp.quo;
    if (state == dbt_pkg::ST_UPD && k != dbt_pkg::K_FIXED) begin
      case (sns)
        dbt_pkg::S_EQ: begin
          fv <= q; lb <= q; hb <= q; k <= dbt_pkg::K_FIXED; chg <= chg + 2'd1;
        end
        dbt_pkg::S_LE, dbt_pkg::S_GE: begin
          if (raise_low) begin
            if (k == dbt_pkg::K_LOW || k == dbt_pkg::K_BOTH) begin
              if ($signed(q) > $signed(lb)) begin lb <= q; chg <= chg + 2'd1; end
            end else begin
              lb <= q; chg <= chg + 2'd1;
              k <= (k == dbt_pkg::K_HIGH) ? dbt_pkg::K_BOTH : dbt_pkg::K_LOW;
            end
          end else begin
            if (k == dbt_pkg::K_HIGH || k == dbt_pkg::K_BOTH) begin
              if ($signed(q) < $signed(hb)) begin hb <= q; chg <= chg + 2'd1; end
            end else begin
              hb <= q; chg <= chg + 2'd1;
              k <= (k == dbt_pkg::K_LOW) ? dbt_pkg::K_BOTH : dbt_pkg::K_HIGH;
            end
          end
        end
        default: ;
      endcase
    end
    if (state == dbt_pkg::ST_COLL && k == dbt_pkg::K_BOTH && agap < {2'd0, tol}) begin
      fv <= sum[32:1]; lb <= sum[32:1]; hb <= sum[32:1];
      k <= dbt_pkg::K_FIXED; chg <= chg + 2'd1;
    end
    if ((state == dbt_pkg::ST_OUT) && (!out_valid || out_ready)) begin
      if (oor) begin
        changes <= 2'd0; known_state <= 3'd0;
        dual_value <= '0; lower_bound <= '0; upper_bound <= '0;
      end else begin
        changes <= chg;
        known_state <= k;
        dual_value <= (k == dbt_pkg::K_FIXED) ? fv : 32'd0;
        lower_bound <= (k == dbt_pkg::K_FIXED || k == dbt_pkg::K_LOW ||
                        k == dbt_pkg::K_BOTH) ? lb : 32'd0;
        upper_bound <= (k == dbt_pkg::K_FIXED || k == dbt_pkg::K_HIGH ||
                        k == dbt_pkg::K_BOTH) ? hb : 32'd0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != dbt_pkg::ST_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == dbt_pkg::ST_DIV)) else $error("stray divider result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(known_state))
    else $error("result dropped");
`endif
endmodule
